FILE: rtl/rmq_pkg.sv
// shared constants for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_W        = 18;

  // branch codes
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_M00   = 2'd1;
  localparam logic [1:0] BR_M11   = 2'd2;
  localparam logic [1:0] BR_M22   = 2'd3;

endpackage

FILE: rtl/rotation_matrix_to_quaternion.sv
// rotation matrix to unit quaternion, pipelined square root and dividers
// depends on rmq_pkg
//
// channel  dir  fields (lowest bit up)
// in_      in   tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22
// out_     out  tdata: quat_x quat_y quat_z quat_w; tuser: branch_taken
//
// one word per cycle while the output is not stalled; DW is the root width (20 at 16
// fraction bits), one root bit per square root stage, followed by the 18 quotient
// stages of the dividers. reset clears only valid bits. a stall at the output holds
// every stage; nothing is lost or repeated.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // quat_x quat_y quat_z quat_w
  output logic [1:0]   out_tuser   // branch_taken
);

  localparam int RSW = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;
  localparam int RU  = RSW - 1;
  localparam int XW  = RU + FRAC_BITS + 2;
  localparam int XE  = XW + (XW % 2);
  localparam int DW  = XE / 2;
  localparam int NW  = 19 + FRAC_BITS + 2;
  localparam int CW  = ((NW > DW + 19) ? NW : DW + 19) + 1;
  localparam int QB  = ELEM_W;
  localparam logic signed [RSW-1:0] ONE_S = RSW'(1) << FRAC_BITS;

  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // input unpack
  logic signed [ELEM_W-1:0] m [9];
  always_comb begin
    for (int i = 0; i < 9; i++) m[i] = in_tdata[i*ELEM_W +: ELEM_W];
  end

  // branch select, radicand and numerators
  logic signed [RSW-1:0] tr, r_raw;
  logic [RU-1:0]         r_u;
  logic [1:0]            br_c;
  logic signed [18:0]    n_c [3];
  logic signed [18:0]    d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  always_comb begin
    tr = RSW'(m[0]) + RSW'(m[4]) + RSW'(m[8]);
    d21_12 = 19'(m[7]) - 19'(m[5]);
    d02_20 = 19'(m[2]) - 19'(m[6]);
    d10_01 = 19'(m[3]) - 19'(m[1]);
    s01_10 = 19'(m[1]) + 19'(m[3]);
    s02_20 = 19'(m[2]) + 19'(m[6]);
    s12_21 = 19'(m[5]) + 19'(m[7]);
    if (tr > 0) begin
      br_c = BR_TRACE;
      r_raw = ONE_S + tr;
      n_c[0] = d21_12; n_c[1] = d02_20; n_c[2] = d10_01;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br_c = BR_M00;
      r_raw = ONE_S + RSW'(m[0]) - RSW'(m[4]) - RSW'(m[8]);
      n_c[0] = d21_12; n_c[1] = s01_10; n_c[2] = s02_20;
    end else if (m[4] > m[8]) begin
      br_c = BR_M11;
      r_raw = ONE_S + RSW'(m[4]) - RSW'(m[0]) - RSW'(m[8]);
      n_c[0] = d02_20; n_c[1] = s01_10; n_c[2] = s12_21;
    end else begin
      br_c = BR_M22;
      r_raw = ONE_S + RSW'(m[8]) - RSW'(m[0]) - RSW'(m[4]);
      n_c[0] = d10_01; n_c[1] = s02_20; n_c[2] = s12_21;
    end
    if (r_raw <= 0) r_u = RU'(1);
    else r_u = r_raw[RU-1:0];
  end

  // square root section, one root bit per stage
  logic                 sv_r   [0:DW];
  logic [1:0]           sbr_r  [0:DW];
  logic signed [18:0]   sn_r   [0:DW][3];
  logic [XE-1:0]        sx_r   [0:DW];
  logic [DW-1:0]        sq_r   [0:DW];
  logic [DW:0]          srem_r [0:DW];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else if (adv) sv_r[0] <= in_tvalid;
    if (adv) begin
      sbr_r[0]  <= br_c;
      sn_r[0]   <= n_c;
      sx_r[0]   <= XE'(r_u) << (FRAC_BITS + 2);
      sq_r[0]   <= '0;
      srem_r[0] <= '0;
    end
  end

  genvar k;
  for (k = 0; k < DW; k++) begin : g_sq
    logic [DW+2:0] cur, trial, diff;
    logic          take;
    always_comb begin
      cur   = {srem_r[k], sx_r[k][XE-1 -: 2]};
      trial = {1'b0, sq_r[k], 2'b01};
      diff  = cur - trial;
      take  = cur >= trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k+1] <= 1'b0;
      else if (adv) sv_r[k+1] <= sv_r[k];
      if (adv) begin
        sbr_r[k+1]  <= sbr_r[k];
        sn_r[k+1]   <= sn_r[k];
        sx_r[k+1]   <= sx_r[k] << 2;
        sq_r[k+1]   <= {sq_r[k][DW-2:0], take};
        srem_r[k+1] <= take ? diff[DW:0] : cur[DW:0];
      end
    end
  end

  // divider setup: magnitudes, rounding offset, overflow check
  logic [DW-1:0]     dd;
  logic [DW:0]       dv_c;
  logic [DW:0]       rt_c;
  logic [ELEM_W-1:0] root_c;
  logic [18:0]       mag_c [3];
  logic [NW-1:0]     num_c [3];
  logic              ovf_c [3];
  always_comb begin
    dd     = sq_r[DW];
    dv_c   = {dd, 1'b0};
    rt_c   = ((DW+1)'(dd) + (DW+1)'(2)) >> 2;
    root_c = (rt_c > (DW+1)'(131071)) ? ELEM_W'(131071) : rt_c[ELEM_W-1:0];
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = sn_r[DW][i][18] ? 19'(-sn_r[DW][i]) : 19'(sn_r[DW][i]);
      num_c[i] = (NW'(mag_c[i]) << (FRAC_BITS + 1)) + NW'(dd);
      ovf_c[i] = CW'(num_c[i]) >= (CW'(dv_c) << QB);
    end
  end

  logic              dvl_r  [0:QB];
  logic [1:0]        dbr_r  [0:QB];
  logic [ELEM_W-1:0] drt_r  [0:QB];
  logic [DW:0]       ddv_r  [0:QB];
  logic [NW-1:0]     drem_r [0:QB][3];
  logic [QB-1:0]     dq_r   [0:QB][3];
  logic              dneg_r [0:QB][3];
  logic              dovf_r [0:QB][3];

  always_ff @(posedge clk) begin
    if (!rst_n) dvl_r[0] <= 1'b0;
    else if (adv) dvl_r[0] <= sv_r[DW];
    if (adv) begin
      dbr_r[0] <= sbr_r[DW];
      drt_r[0] <= root_c;
      ddv_r[0] <= dv_c;
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= num_c[i];
        dq_r[0][i]   <= '0;
        dneg_r[0][i] <= sn_r[DW][i][18];
        dovf_r[0][i] <= ovf_c[i];
      end
    end
  end

  // restoring division, one quotient bit per stage, msb first
  genvar j;
  for (j = 0; j < QB; j++) begin : g_dv
    localparam int B = QB - 1 - j;
    logic [CW-1:0] sh;
    logic          take [3];
    always_comb begin
      sh = CW'(ddv_r[j]) << B;
      for (int i = 0; i < 3; i++)
        take[i] = !dovf_r[j][i] && (CW'(drem_r[j][i]) >= sh);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dvl_r[j+1] <= 1'b0;
      else if (adv) dvl_r[j+1] <= dvl_r[j];
      if (adv) begin
        dbr_r[j+1] <= dbr_r[j];
        drt_r[j+1] <= drt_r[j];
        ddv_r[j+1] <= ddv_r[j];
        for (int i = 0; i < 3; i++) begin
          drem_r[j+1][i] <= take[i] ? drem_r[j][i] - sh[NW-1:0] : drem_r[j][i];
          dq_r[j+1][i]   <= dq_r[j][i] | (take[i] ? (QB'(1) << B) : '0);
          dneg_r[j+1][i] <= dneg_r[j][i];
          dovf_r[j+1][i] <= dovf_r[j][i];
        end
      end
    end
  end

  // sign, saturation and placement by branch
  logic [ELEM_W-1:0] cv [3];
  logic [ELEM_W-1:0] qx, qy, qz, qw;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dneg_r[QB][i]) begin
        if (dovf_r[QB][i] || (dq_r[QB][i][QB-1] && dq_r[QB][i][QB-2:0] != '0))
          cv[i] = ELEM_W'(131072);
        else
          cv[i] = ELEM_W'(-dq_r[QB][i]);
      end else begin
        if (dovf_r[QB][i] || dq_r[QB][i][QB-1]) cv[i] = ELEM_W'(131071);
        else cv[i] = dq_r[QB][i];
      end
    end
    unique case (dbr_r[QB])
      BR_TRACE: begin qw = drt_r[QB]; qx = cv[0]; qy = cv[1]; qz = cv[2]; end
      BR_M00:   begin qx = drt_r[QB]; qw = cv[0]; qy = cv[1]; qz = cv[2]; end
      BR_M11:   begin qy = drt_r[QB]; qw = cv[0]; qx = cv[1]; qz = cv[2]; end
      default:  begin qz = drt_r[QB]; qw = cv[0]; qx = cv[1]; qy = cv[2]; end
    endcase
  end

  // output register
  logic        ov_r;
  logic [71:0] od_r;
  logic [1:0]  ou_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= dvl_r[QB];
    if (adv) begin
      od_r <= {qw, qz, qy, qx};
      ou_r <= dbr_r[QB];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule
